/* rtl/pfc_pkg.sv */
package pfc_pkg;

  localparam int unsigned CodeW  = 5;
  localparam int unsigned Side   = 5;
  localparam int unsigned Cells  = Side * Side;
  localparam int unsigned LowW   = 45;
  localparam int unsigned MidW   = 40;
  localparam int unsigned HighW  = 40;
  localparam int unsigned CfgW   = LowW;
  localparam int unsigned PosW   = 3;

  localparam logic [CodeW-1:0] LETTER_X = 5'd23;
  localparam logic [CodeW-1:0] LETTER_J = 5'd9;
  localparam logic [CodeW-1:0] LETTER_I = 5'd8;
  localparam logic [PosW-1:0]  SIDE_LAST = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_DIRECTION = 2'd0;
  localparam logic [1:0] REG_CELLS_LO  = 2'd1;
  localparam logic [1:0] REG_CELLS_MID = 2'd2;
  localparam logic [1:0] REG_CELLS_HI  = 2'd3;

  typedef struct packed {
    logic [CodeW-1:0] letter_code;
    logic             message_end;
  } in_t;

  typedef struct packed {
    logic [CodeW-1:0] out_first;
    logic [CodeW-1:0] out_second;
    logic             lookup_miss;
    logic             final_pair;
  } out_t;

endpackage

/* rtl/playfair_digraph_cipher_unit.sv */
// Channel   | ports                          | transfer when
// ----------+--------------------------------+-------------------------------
// input     | in_valid, in_stall, in_data    | in_valid & !in_stall
// result    | out_valid, out_stall, out_data | out_valid & !out_stall
// config    | cfg_we, cfg_index, cfg_wdata   | cfg_we (no handshake)
//
// One letter per cycle while in_stall is low. A completed pair is registered in the
// pair register, then its digraph is registered in the output register.
// An encrypted doubled pair that also ends the message yields two digraphs;
// the spare register then holds the second pair and the input stalls until the pair register takes it.
// Reset (rst_n low, synchronous) empties both stages, clears the held letter
// and the configuration. A stalled output backs up through both stages.
module playfair_digraph_cipher_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pfc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output pfc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [pfc_pkg::CfgW-1:0] cfg_wdata
);

  // configuration
  logic                          dir_r;
  logic [pfc_pkg::LowW-1:0]      cells_lo_r;
  logic [pfc_pkg::MidW-1:0]      cells_mid_r;
  logic [pfc_pkg::HighW-1:0]     cells_hi_r;
  logic [pfc_pkg::Cells*pfc_pkg::CodeW-1:0] cells_flat;

  // pairing state
  logic                          held_valid_r, held_valid_nxt;
  logic [pfc_pkg::CodeW-1:0]     held_letter_r, held_letter_nxt;

  // pair register and spare pair
  logic                          p_valid_r, p_valid_nxt;
  logic [pfc_pkg::CodeW-1:0]     p_a_r, p_a_nxt, p_b_r, p_b_nxt;
  logic                          p_last_r, p_last_nxt;
  logic                          x_valid_r, x_valid_nxt;
  logic [pfc_pkg::CodeW-1:0]     x_a_r, x_a_nxt;

  // output register
  logic                          o_valid_r;
  pfc_pkg::out_t                 o_data_r;
  pfc_pkg::out_t                 emit_res;

  logic                          o_load_ok, p_adv, in_acc;
  logic [pfc_pkg::CodeW-1:0]     letter;
  logic                          gen1, gen2;
  logic [pfc_pkg::CodeW-1:0]     g_a, g_b;
  logic                          g_last;

  assign cells_flat = {cells_hi_r, cells_mid_r, cells_lo_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dir_r       <= 1'b0;
      cells_lo_r  <= '0;
      cells_mid_r <= '0;
      cells_hi_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        pfc_pkg::REG_DIRECTION: dir_r       <= cfg_wdata[0];
        pfc_pkg::REG_CELLS_LO:  cells_lo_r  <= cfg_wdata;
        pfc_pkg::REG_CELLS_MID: cells_mid_r <= cfg_wdata[pfc_pkg::MidW-1:0];
        pfc_pkg::REG_CELLS_HI:  cells_hi_r  <= cfg_wdata[pfc_pkg::HighW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake. The spare pair blocks the input until it moves into the pair register.
  assign o_load_ok = !o_valid_r || !out_stall;
  assign p_adv     = p_valid_r && o_load_ok;
  assign in_stall  = x_valid_r || (p_valid_r && !o_load_ok);
  assign in_acc    = in_valid && !in_stall;

  // Pairing: J folds to I when encrypting; doubled letters and an odd end
  // get X when encrypting; an odd end is dropped when decrypting.
  always_comb begin
    letter = in_data.letter_code;
    if (!dir_r && letter == pfc_pkg::LETTER_J) begin
      letter = pfc_pkg::LETTER_I;
    end
    gen1            = 1'b0;
    gen2            = 1'b0;
    g_a             = held_letter_r;
    g_b             = letter;
    g_last          = in_data.message_end;
    held_valid_nxt  = held_valid_r;
    held_letter_nxt = held_letter_r;
    if (dir_r) begin
      if (held_valid_r) begin
        gen1            = 1'b1;
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end else if (in_data.message_end) begin
        held_valid_nxt  = 1'b0;
        held_letter_nxt = '0;
      end else begin
        held_valid_nxt  = 1'b1;
        held_letter_nxt = letter;
      end
    end else begin
      if (held_valid_r) begin
        gen1 = 1'b1;
        if (held_letter_r == letter) begin
          g_b    = pfc_pkg::LETTER_X;
          g_last = 1'b0;
          if (in_data.message_end) begin
            gen2            = 1'b1;
            held_valid_nxt  = 1'b0;
            held_letter_nxt = '0;
          end else begin
            held_valid_nxt  = 1'b1;
            held_letter_nxt = letter;
          end
        end else begin
          held_valid_nxt  = 1'b0;
          held_letter_nxt = '0;
        end
      end else if (in_data.message_end) begin
        gen1   = 1'b1;
        g_a    = letter;
        g_b    = pfc_pkg::LETTER_X;
        g_last = 1'b1;
      end else begin
        held_valid_nxt  = 1'b1;
        held_letter_nxt = letter;
      end
    end
  end

  always_comb begin
    p_valid_nxt = p_valid_r;
    p_a_nxt     = p_a_r;
    p_b_nxt     = p_b_r;
    p_last_nxt  = p_last_r;
    x_valid_nxt = x_valid_r;
    x_a_nxt     = x_a_r;
    if (x_valid_r && p_adv) begin
      p_valid_nxt = 1'b1;
      p_a_nxt     = x_a_r;
      p_b_nxt     = pfc_pkg::LETTER_X;
      p_last_nxt  = 1'b1;
      x_valid_nxt = 1'b0;
    end else if (in_acc && gen1) begin
      p_valid_nxt = 1'b1;
      p_a_nxt     = g_a;
      p_b_nxt     = g_b;
      p_last_nxt  = g_last;
      x_valid_nxt = gen2;
      x_a_nxt     = letter;
    end else if (p_adv) begin
      p_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_valid_r  <= 1'b0;
      held_letter_r <= '0;
      p_valid_r     <= 1'b0;
      x_valid_r     <= 1'b0;
      o_valid_r     <= 1'b0;
    end else begin
      if (in_acc) begin
        held_valid_r  <= held_valid_nxt;
        held_letter_r <= held_letter_nxt;
      end
      p_valid_r <= p_valid_nxt;
      x_valid_r <= x_valid_nxt;
      if (o_load_ok) begin
        o_valid_r <= p_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_a_r    <= p_a_nxt;
    p_b_r    <= p_b_nxt;
    p_last_r <= p_last_nxt;
    x_a_r    <= x_a_nxt;
    if (p_adv) begin
      o_data_r <= emit_res;
    end
  end

  // ---- digraph transform: 25 parallel compares per letter ----
  logic                      fa, fb;
  logic [pfc_pkg::PosW-1:0]  ra, ca, rb, cb;
  logic [pfc_pkg::PosW-1:0]  ra2, ca2, rb2, cb2;
  logic [pfc_pkg::CodeW-1:0] ia, ib;

  function automatic logic [pfc_pkg::PosW-1:0] step_pos(
    input logic [pfc_pkg::PosW-1:0] p, input logic back);
    logic [pfc_pkg::PosW-1:0] r;
    if (back) begin
      r = (p == '0) ? pfc_pkg::SIDE_LAST : p - 1'b1;
    end else begin
      r = (p == pfc_pkg::SIDE_LAST) ? '0 : p + 1'b1;
    end
    return r;
  endfunction

  always_comb begin
    fa = 1'b0;
    fb = 1'b0;
    ra = '0;
    ca = '0;
    rb = '0;
    cb = '0;
    // ascending scan: highest matching cell wins
    for (int i = 0; i < pfc_pkg::Cells; i++) begin
      if (cells_flat[i*pfc_pkg::CodeW +: pfc_pkg::CodeW] == p_a_r) begin
        fa = 1'b1;
        ra = pfc_pkg::PosW'(i / pfc_pkg::Side);
        ca = pfc_pkg::PosW'(i % pfc_pkg::Side);
      end
      if (cells_flat[i*pfc_pkg::CodeW +: pfc_pkg::CodeW] == p_b_r) begin
        fb = 1'b1;
        rb = pfc_pkg::PosW'(i / pfc_pkg::Side);
        cb = pfc_pkg::PosW'(i % pfc_pkg::Side);
      end
    end
    ra2 = ra;
    ca2 = ca;
    rb2 = rb;
    cb2 = cb;
    if (ra == rb) begin
      ca2 = step_pos(ca, dir_r);
      cb2 = step_pos(cb, dir_r);
    end else if (ca == cb) begin
      ra2 = step_pos(ra, dir_r);
      rb2 = step_pos(rb, dir_r);
    end else begin
      ca2 = cb;
      cb2 = ca;
    end
    // cell = 5*row + col
    ia = {ra2, 2'b00} + {2'b00, ra2} + {2'b00, ca2};
    ib = {rb2, 2'b00} + {2'b00, rb2} + {2'b00, cb2};
    emit_res.final_pair = p_last_r;
    if (!fa || !fb) begin
      emit_res.out_first   = '0;
      emit_res.out_second  = '0;
      emit_res.lookup_miss = 1'b1;
    end else begin
      emit_res.out_first   = cells_flat[ia*pfc_pkg::CodeW +: pfc_pkg::CodeW];
      emit_res.out_second  = cells_flat[ib*pfc_pkg::CodeW +: pfc_pkg::CodeW];
      emit_res.lookup_miss = 1'b0;
    end
  end

  assign out_valid = o_valid_r;
  assign out_data  = o_data_r;

endmodule

/* rtl/pfc_checker.sv */
module pfc_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_stall,
  input pfc_pkg::in_t  in_data,
  input logic          out_valid,
  input logic          out_stall,
  input pfc_pkg::out_t out_data
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // nothing shows right after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a miss carries zero letters
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.lookup_miss |->
      out_data.out_first == '0 && out_data.out_second == '0)
    else $error("miss with nonzero letters");

  // input stalls only while a result waits or for the spare pair of an end
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |->
      out_valid || $past(in_valid && !in_stall && in_data.message_end))
    else $error("unexplained input stall");

endmodule

bind playfair_digraph_cipher_unit pfc_checker u_pfc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
